// ===== hw/rtl/qsnl_pkg.sv =====
// Shared constants and types for the quadtree segment node locator.
`timescale 1ns / 1ps
package qsnl_pkg;

	// Port widths fixed by the interface
	localparam int COORD_W    = 32;
	localparam int LEVELS_W   = 4;
	localparam int LEVEL_W    = 3;
	localparam int PATH_W     = 14;
	localparam int CFG_IDX_W  = 3;

	// Parameter defaults
	localparam int DEF_MAX_LEVELS = 8;
	localparam int DEF_COORD_BITS = 32;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MIN_X  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_X  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_Y  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_Y  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LEVELS = 3'd4;

	// Register reset values
	localparam logic [COORD_W-1:0]  RST_MIN_X  = 32'd0;
	localparam logic [COORD_W-1:0]  RST_MAX_X  = 32'd65535;
	localparam logic [COORD_W-1:0]  RST_MIN_Y  = 32'd0;
	localparam logic [COORD_W-1:0]  RST_MAX_Y  = 32'd65535;
	localparam logic [LEVELS_W-1:0] RST_LEVELS = 4'd8;

	// Quadrant codes
	localparam logic [1:0] QUAD_UR = 2'd0;
	localparam logic [1:0] QUAD_UL = 2'd1;
	localparam logic [1:0] QUAD_LL = 2'd2;
	localparam logic [1:0] QUAD_LR = 2'd3;

	// Control that travels with each word down the pipeline
	typedef struct packed {
		logic valid;
		logic active;
	} ctl_t;

endpackage

// ===== hw/rtl/qsnl_level.sv =====
// One tree level of the descent: midpoint stage, then child test and select stage.
`timescale 1ns / 1ps
module qsnl_level #(
	parameter int CB     = qsnl_pkg::DEF_COORD_BITS,
	parameter int LVL_W  = 4,
	parameter int PW     = 16,
	parameter int K      = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  qsnl_pkg::ctl_t       ctl_in,
	input  logic signed [CB-1:0] ax_in,
	input  logic signed [CB-1:0] ay_in,
	input  logic signed [CB-1:0] bx_in,
	input  logic signed [CB-1:0] by_in,
	input  logic signed [CB-1:0] lx_in,
	input  logic signed [CB-1:0] hx_in,
	input  logic signed [CB-1:0] ly_in,
	input  logic signed [CB-1:0] hy_in,
	input  logic [LVL_W-1:0]     level_in,
	input  logic [LVL_W-1:0]     levels_in,
	input  logic [PW-1:0]        path_in,
	output qsnl_pkg::ctl_t       ctl_out,
	output logic signed [CB-1:0] ax_out,
	output logic signed [CB-1:0] ay_out,
	output logic signed [CB-1:0] bx_out,
	output logic signed [CB-1:0] by_out,
	output logic signed [CB-1:0] lx_out,
	output logic signed [CB-1:0] hx_out,
	output logic signed [CB-1:0] ly_out,
	output logic signed [CB-1:0] hy_out,
	output logic [LVL_W-1:0]     level_out,
	output logic [LVL_W-1:0]     levels_out,
	output logic [PW-1:0]        path_out
);

	// Stage 1: midpoints, lo + floor((hi - lo) / 2) at one extra bit
	logic signed [CB:0]   dx, dy, sx, sy;
	logic signed [CB-1:0] mx, my;

	always_comb begin
		dx = {hx_in[CB-1], hx_in} - {lx_in[CB-1], lx_in};
		dy = {hy_in[CB-1], hy_in} - {ly_in[CB-1], ly_in};
		sx = {lx_in[CB-1], lx_in} + (dx >>> 1);
		sy = {ly_in[CB-1], ly_in} + (dy >>> 1);
		mx = sx[CB-1:0];
		my = sy[CB-1:0];
	end

	qsnl_pkg::ctl_t       ctl_s1;
	logic signed [CB-1:0] ax_s1, ay_s1, bx_s1, by_s1;
	logic signed [CB-1:0] lx_s1, hx_s1, ly_s1, hy_s1, mx_s1, my_s1;
	logic [LVL_W-1:0]     level_s1, levels_s1;
	logic [PW-1:0]        path_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1     <= ax_in;
			ay_s1     <= ay_in;
			bx_s1     <= bx_in;
			by_s1     <= by_in;
			lx_s1     <= lx_in;
			hx_s1     <= hx_in;
			ly_s1     <= ly_in;
			hy_s1     <= hy_in;
			mx_s1     <= mx;
			my_s1     <= my;
			level_s1  <= level_in;
			levels_s1 <= levels_in;
			path_s1   <= path_in;
		end
	end

	// Stage 2: test children in order UR, UL, LL, LR and step into the first hit
	logic a_hi_x, a_lo_x, a_hi_y, a_lo_y;
	logic b_hi_x, b_lo_x, b_hi_y, b_lo_y;
	logic in_ur, in_ul, in_ll, in_lr, deeper;
	logic [LVL_W:0] next_lvl;

	always_comb begin
		// right half [mx, hx], left half [lx, mx], top [my, hy], bottom [ly, my]
		a_hi_x = (ax_s1 >= mx_s1) && (ax_s1 <= hx_s1);
		a_lo_x = (ax_s1 >= lx_s1) && (ax_s1 <= mx_s1);
		a_hi_y = (ay_s1 >= my_s1) && (ay_s1 <= hy_s1);
		a_lo_y = (ay_s1 >= ly_s1) && (ay_s1 <= my_s1);
		b_hi_x = (bx_s1 >= mx_s1) && (bx_s1 <= hx_s1);
		b_lo_x = (bx_s1 >= lx_s1) && (bx_s1 <= mx_s1);
		b_hi_y = (by_s1 >= my_s1) && (by_s1 <= hy_s1);
		b_lo_y = (by_s1 >= ly_s1) && (by_s1 <= my_s1);
		in_ur  = a_hi_x && a_hi_y && b_hi_x && b_hi_y;
		in_ul  = a_lo_x && a_hi_y && b_lo_x && b_hi_y;
		in_ll  = a_lo_x && a_lo_y && b_lo_x && b_lo_y;
		in_lr  = a_hi_x && a_lo_y && b_hi_x && b_lo_y;
		next_lvl = (LVL_W+1)'(K + 1);
		deeper = ctl_s1.active && (next_lvl < {1'b0, levels_s1});
	end

	qsnl_pkg::ctl_t       ctl_s2;
	logic signed [CB-1:0] lx_s2, hx_s2, ly_s2, hy_s2;
	logic [LVL_W-1:0]     level_s2;
	logic [PW-1:0]        path_s2;
	logic signed [CB-1:0] ax_s2, ay_s2, bx_s2, by_s2;
	logic [LVL_W-1:0]     levels_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s2.valid  <= ctl_s1.valid;
			ctl_s2.active <= deeper && (in_ur || in_ul || in_ll || in_lr);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s2     <= ax_s1;
			ay_s2     <= ay_s1;
			bx_s2     <= bx_s1;
			by_s2     <= by_s1;
			levels_s2 <= levels_s1;
			lx_s2     <= lx_s1;
			hx_s2     <= hx_s1;
			ly_s2     <= ly_s1;
			hy_s2     <= hy_s1;
			level_s2  <= level_s1;
			path_s2   <= path_s1;
			if (deeper && (in_ur || in_ul || in_ll || in_lr)) begin
				level_s2 <= next_lvl[LVL_W-1:0];
				if (in_ur) begin
					path_s2[2*K +: 2] <= qsnl_pkg::QUAD_UR;
					lx_s2 <= mx_s1;
					ly_s2 <= my_s1;
				end else if (in_ul) begin
					path_s2[2*K +: 2] <= qsnl_pkg::QUAD_UL;
					hx_s2 <= mx_s1;
					ly_s2 <= my_s1;
				end else if (in_ll) begin
					path_s2[2*K +: 2] <= qsnl_pkg::QUAD_LL;
					hx_s2 <= mx_s1;
					hy_s2 <= my_s1;
				end else begin
					path_s2[2*K +: 2] <= qsnl_pkg::QUAD_LR;
					lx_s2 <= mx_s1;
					hy_s2 <= my_s1;
				end
			end
		end
	end

	assign ctl_out    = ctl_s2;
	assign ax_out     = ax_s2;
	assign ay_out     = ay_s2;
	assign bx_out     = bx_s2;
	assign by_out     = by_s2;
	assign lx_out     = lx_s2;
	assign hx_out     = hx_s2;
	assign ly_out     = ly_s2;
	assign hy_out     = hy_s2;
	assign level_out  = level_s2;
	assign levels_out = levels_s2;
	assign path_out   = path_s2;

endmodule

// ===== hw/rtl/quadtree_segment_node_locate.sv =====
// Top level: quadtree segment node locator with configuration registers.
//
// Segments enter on the seg channel (seg_valid / seg_stall, fields x0 y0 x1 y1).
// For each segment one word leaves on the node channel (node_valid / node_stall)
// with node_level, node_path and is_leaf. Words leave in the order they came in.
// The root region and the level count are written on the cfg channel
// (cfg_valid / cfg_ready, cfg_index, cfg_data); cfg_ready is always high.
// Write them only while no segment is in flight.
// The pipeline is one entry register, two register stages per descent level
// (midpoint, then child test and select) for MAX_LEVELS - 1 levels, and the
// output register. Throughput is one segment per cycle while the output is not stalled.
// When node_stall is high with a word on the output, the whole pipeline holds
// and seg_stall rises in the same cycle; nothing is dropped or repeated.
// Reset clears all valid bits and loads the root region 0..65535 in x and y
// with eight levels. Coordinates are taken as signed COORD_BITS-bit values.
`timescale 1ns / 1ps
module quadtree_segment_node_locate #(
	parameter int MAX_LEVELS = qsnl_pkg::DEF_MAX_LEVELS,
	parameter int COORD_BITS = qsnl_pkg::DEF_COORD_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 seg_valid,
	output logic                                 seg_stall,
	input  logic [qsnl_pkg::COORD_W-1:0]         x0,
	input  logic [qsnl_pkg::COORD_W-1:0]         y0,
	input  logic [qsnl_pkg::COORD_W-1:0]         x1,
	input  logic [qsnl_pkg::COORD_W-1:0]         y1,
	output logic                                 node_valid,
	input  logic                                 node_stall,
	output logic [qsnl_pkg::LEVEL_W-1:0]         node_level,
	output logic [qsnl_pkg::PATH_W-1:0]          node_path,
	output logic                                 is_leaf,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [qsnl_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [qsnl_pkg::COORD_W-1:0]         cfg_data
);

	localparam int CB    = COORD_BITS;
	localparam int LVL_W = $clog2(MAX_LEVELS + 1);
	localparam int PW    = 2 * MAX_LEVELS;

	// Configuration registers
	logic [qsnl_pkg::COORD_W-1:0]  min_x_q, max_x_q, min_y_q, max_y_q;
	logic [qsnl_pkg::LEVELS_W-1:0] levels_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_x_q  <= qsnl_pkg::RST_MIN_X;
			max_x_q  <= qsnl_pkg::RST_MAX_X;
			min_y_q  <= qsnl_pkg::RST_MIN_Y;
			max_y_q  <= qsnl_pkg::RST_MAX_Y;
			levels_q <= qsnl_pkg::RST_LEVELS;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				qsnl_pkg::REG_MIN_X:  min_x_q  <= cfg_data;
				qsnl_pkg::REG_MAX_X:  max_x_q  <= cfg_data;
				qsnl_pkg::REG_MIN_Y:  min_y_q  <= cfg_data;
				qsnl_pkg::REG_MAX_Y:  max_y_q  <= cfg_data;
				qsnl_pkg::REG_LEVELS: levels_q <= cfg_data[qsnl_pkg::LEVELS_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp the level count to 1..MAX_LEVELS
	logic [4:0]       levels_wide;
	logic [LVL_W-1:0] levels_eff;

	always_comb begin
		levels_wide = {1'b0, levels_q};
		if (levels_wide == 5'd0) begin
			levels_eff = LVL_W'(1);
		end else if (levels_wide > 5'(MAX_LEVELS)) begin
			levels_eff = LVL_W'(MAX_LEVELS);
		end else begin
			levels_eff = levels_wide[LVL_W-1:0];
		end
	end

	// Global advance: hold everything while the output word is stalled
	logic en;
	assign en        = !(node_valid && node_stall);
	assign seg_stall = !en;

	// Taps between levels; index 0 is the entry register
	qsnl_pkg::ctl_t       ctl_c    [MAX_LEVELS];
	logic signed [CB-1:0] ax_c     [MAX_LEVELS];
	logic signed [CB-1:0] ay_c     [MAX_LEVELS];
	logic signed [CB-1:0] bx_c     [MAX_LEVELS];
	logic signed [CB-1:0] by_c     [MAX_LEVELS];
	logic signed [CB-1:0] lx_c     [MAX_LEVELS];
	logic signed [CB-1:0] hx_c     [MAX_LEVELS];
	logic signed [CB-1:0] ly_c     [MAX_LEVELS];
	logic signed [CB-1:0] hy_c     [MAX_LEVELS];
	logic [LVL_W-1:0]     level_c  [MAX_LEVELS];
	logic [LVL_W-1:0]     levels_c [MAX_LEVELS];
	logic [PW-1:0]        path_c   [MAX_LEVELS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_c[0] <= '0;
		end else if (en) begin
			ctl_c[0].valid  <= seg_valid;
			ctl_c[0].active <= seg_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_c[0]     <= x0[CB-1:0];
			ay_c[0]     <= y0[CB-1:0];
			bx_c[0]     <= x1[CB-1:0];
			by_c[0]     <= y1[CB-1:0];
			lx_c[0]     <= min_x_q[CB-1:0];
			hx_c[0]     <= max_x_q[CB-1:0];
			ly_c[0]     <= min_y_q[CB-1:0];
			hy_c[0]     <= max_y_q[CB-1:0];
			level_c[0]  <= '0;
			levels_c[0] <= levels_eff;
			path_c[0]   <= '0;
		end
	end

	for (genvar k = 0; k < MAX_LEVELS - 1; k++) begin : g_lvl
		qsnl_level #(
			.CB    (CB),
			.LVL_W (LVL_W),
			.PW    (PW),
			.K     (k)
		) u_level (
			.clk        (clk),
			.arst_n     (arst_n),
			.en         (en),
			.ctl_in     (ctl_c[k]),
			.ax_in      (ax_c[k]),
			.ay_in      (ay_c[k]),
			.bx_in      (bx_c[k]),
			.by_in      (by_c[k]),
			.lx_in      (lx_c[k]),
			.hx_in      (hx_c[k]),
			.ly_in      (ly_c[k]),
			.hy_in      (hy_c[k]),
			.level_in   (level_c[k]),
			.levels_in  (levels_c[k]),
			.path_in    (path_c[k]),
			.ctl_out    (ctl_c[k+1]),
			.ax_out     (ax_c[k+1]),
			.ay_out     (ay_c[k+1]),
			.bx_out     (bx_c[k+1]),
			.by_out     (by_c[k+1]),
			.lx_out     (lx_c[k+1]),
			.hx_out     (hx_c[k+1]),
			.ly_out     (ly_c[k+1]),
			.hy_out     (hy_c[k+1]),
			.level_out  (level_c[k+1]),
			.levels_out (levels_c[k+1]),
			.path_out   (path_c[k+1])
		);
	end

	// Output register
	logic [LVL_W+qsnl_pkg::LEVEL_W-1:0] lvl_ext;
	logic [PW+qsnl_pkg::PATH_W-1:0]     path_ext;
	logic [LVL_W:0]                     lvl_plus1;
	logic                               out_valid_q;
	logic [qsnl_pkg::LEVEL_W-1:0]       level_q;
	logic [qsnl_pkg::PATH_W-1:0]        path_q;
	logic                               leaf_q;

	always_comb begin
		lvl_ext   = (LVL_W+qsnl_pkg::LEVEL_W)'(level_c[MAX_LEVELS-1]);
		path_ext  = (PW+qsnl_pkg::PATH_W)'(path_c[MAX_LEVELS-1]);
		lvl_plus1 = {1'b0, level_c[MAX_LEVELS-1]} + (LVL_W+1)'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= ctl_c[MAX_LEVELS-1].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			level_q <= lvl_ext[qsnl_pkg::LEVEL_W-1:0];
			path_q  <= path_ext[qsnl_pkg::PATH_W-1:0];
			leaf_q  <= (lvl_plus1 == {1'b0, levels_c[MAX_LEVELS-1]});
		end
	end

	assign node_valid = out_valid_q;
	assign node_level = level_q;
	assign node_path  = path_q;
	assign is_leaf    = leaf_q;

endmodule
